/* sv/peak_profile_evaluator_defines.svh */
// Assertion macros shared by the peak profile evaluator checkers
`ifndef PEAK_PROFILE_EVALUATOR_DEFINES_SVH
`define PEAK_PROFILE_EVALUATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet during reset
`define PPE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ppe check failed");

// Next-cycle implication, sampled on clk and quiet during reset
`define PPE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ppe check failed");

`endif

/* sv/ppe_pkg.sv */
// Shared types, constants and helpers of the peak profile evaluator
package ppe_pkg;

	// Pipeline depth from the difference stage to the result stage
	localparam int PIPE_LAT       = 35;
	localparam int GAUSS_CORE_LAT = 27;

	// Q2.30 shape constants, Q0.32 ln2
	localparam logic [31:0] K_GSCALE = 32'd1008713077;
	localparam logic [31:0] K_GRATE  = 32'd1787897390;
	localparam logic [31:0] K_LSCALE = 32'd683565276;
	localparam logic [31:0] K_LOG2E  = 32'd1549082005;
	localparam logic [31:0] K_LN2    = 32'd2977044472;

	// Register indexes
	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_CENTER = 2'd1;
	localparam logic [1:0] REG_FWHM   = 2'd2;
	localparam logic [1:0] REG_INTEN  = 2'd3;

	typedef struct packed {
		logic signed [31:0] sample_position;
		logic               last_sample;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] peak_value;
		logic               saturated;
		logic               bad_width;
		logic               last_out;
	} out_item_t;

	typedef struct packed {
		logic [31:0] gauss_scale;
		logic [31:0] gauss_rate;
		logic [31:0] lorentz_scale;
		logic [31:0] inverse_half_width;
		logic        gauss_clip;
		logic        lorentz_clip;
		logic        busy;
	} coef_t;

	// Magnitude of a signed 32-bit word (the most negative value maps to 2^31)
	function automatic logic [31:0] mag32(input logic [31:0] v);
		mag32 = v[31] ? (32'd0 - v) : v;
	endfunction

	// floor(2^35 / k) for the series divisions
	function automatic logic [35:0] recip_of(input logic [2:0] k);
		case (k)
			3'd1:    recip_of = 36'd34359738368;
			3'd2:    recip_of = 36'd17179869184;
			3'd3:    recip_of = 36'd11453246122;
			3'd4:    recip_of = 36'd8589934592;
			3'd5:    recip_of = 36'd6871947673;
			3'd6:    recip_of = 36'd5726623061;
			3'd7:    recip_of = 36'd4908534052;
			default: recip_of = 36'd0;
		endcase
	endfunction

endpackage

/* sv/ppe_stream_if.sv */
// Valid/ready stream channel carrying one item per handshake
interface ppe_stream_if #(parameter type item_t = logic);
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* sv/ppe_coef.sv */
// Coefficient unit: shared radix-2 divider deriving scales and rates from width
module ppe_coef (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [31:0]    fwhm,
	input  logic [31:0]    intensity,
	output ppe_pkg::coef_t coef
);
	import ppe_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_LOAD  = 2'd1;
	localparam logic [1:0] ST_STEP  = 2'd2;
	localparam logic [1:0] ST_STORE = 2'd3;

	logic [1:0]  state_q;
	logic [1:0]  idx_q;
	logic [5:0]  cnt_q;
	logic [31:0] rem_q;
	logic [63:0] quo_q;
	logic [31:0] gscale_q, grate_q, lscale_q, ihw_q;
	logic        gclip_q, lclip_q;

	logic [31:0] w, im;
	logic        ineg, wzero;
	logic [63:0] dividend;
	logic [32:0] rem_sh;
	logic        ge;
	logic [32:0] rem_nx;
	logic [49:0] sq, lim, sv;
	logic        sclip, rclip;
	logic [31:0] scale_v, rate_v;

	assign w     = mag32(fwhm);
	assign im    = mag32(intensity);
	assign ineg  = intensity[31];
	assign wzero = (w == 32'd0);

	// Pick the dividend of the current coefficient
	always_comb begin
		case (idx_q)
			REG_MODE:   dividend = {32'd0, im} * {32'd0, K_GSCALE};
			REG_CENTER: dividend = {32'd0, K_GRATE} << 10;
			REG_FWHM:   dividend = {32'd0, im} * {32'd0, K_LSCALE};
			default:    dividend = 64'd1 << 41;
		endcase
	end

	// One restoring step
	assign rem_sh = {rem_q, quo_q[63]};
	assign ge     = (rem_sh >= {1'b0, w});
	assign rem_nx = ge ? (rem_sh - {1'b0, w}) : rem_sh;

	// Clip the finished quotient
	always_comb begin
		sq      = quo_q[63:14];
		lim     = ineg ? (50'd1 << 31) : ((50'd1 << 31) - 50'd1);
		sclip   = (sq > lim);
		sv      = sclip ? lim : sq;
		scale_v = ineg ? (32'd0 - sv[31:0]) : sv[31:0];
		rclip   = |quo_q[63:32];
		rate_v  = rclip ? 32'hFFFF_FFFF : quo_q[31:0];
	end

	// Sequence the four divisions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			idx_q   <= 2'd0;
			cnt_q   <= 6'd0;
			gclip_q <= 1'b0;
			lclip_q <= 1'b0;
		end else if (start) begin
			state_q <= ST_LOAD;
			idx_q   <= 2'd0;
			gclip_q <= 1'b0;
			lclip_q <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					cnt_q   <= 6'd0;
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						state_q <= ST_STORE;
					end
				end
				ST_STORE: begin
					if (!wzero) begin
						case (idx_q)
							REG_MODE, REG_CENTER: gclip_q <= gclip_q | sclip & ~idx_q[0]
								| rclip & idx_q[0];
							default: lclip_q <= lclip_q | sclip & ~idx_q[0]
								| rclip & idx_q[0];
						endcase
					end
					idx_q   <= idx_q + 2'd1;
					state_q <= (idx_q == REG_INTEN) ? ST_IDLE : ST_LOAD;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Divider datapath and coefficient store
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				rem_q <= 32'd0;
				quo_q <= dividend;
			end
			ST_STEP: begin
				rem_q <= rem_nx[31:0];
				quo_q <= {quo_q[62:0], ge};
			end
			ST_STORE: begin
				case (idx_q)
					REG_MODE:   gscale_q <= wzero ? 32'd0 : scale_v;
					REG_CENTER: grate_q  <= wzero ? 32'd0 : rate_v;
					REG_FWHM:   lscale_q <= wzero ? 32'd0 : scale_v;
					default:    ihw_q    <= wzero ? 32'd0 : rate_v;
				endcase
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	assign coef.gauss_scale        = gscale_q;
	assign coef.gauss_rate         = grate_q;
	assign coef.lorentz_scale      = lscale_q;
	assign coef.inverse_half_width = ihw_q;
	assign coef.gauss_clip         = gclip_q;
	assign coef.lorentz_clip       = lclip_q;
	assign coef.busy               = (state_q != ST_IDLE);

endmodule

/* sv/ppe_gauss.sv */
// Gaussian pipeline: scaled distance, exp(-z) by base-2 split and series, scale
module ppe_gauss (
	input  logic        clk,
	input  logic        en,
	input  logic [32:0] dm,
	input  logic [31:0] rate,
	input  logic [31:0] sm,
	output logic [31:0] mag
);
	import ppe_pkg::*;

	localparam int NIT = 7;
	localparam int PAD = PIPE_LAT - GAUSS_CORE_LAT;

	typedef struct packed {
		logic [31:0] g;
		logic [6:0]  n;
		logic        zero;
	} gcarry_t;

	logic [64:0] prod_s1;
	logic [37:0] tsq_s2;
	logic        zero_s2;
	logic [52:0] y_s3;
	logic        zero_s3;
	gcarry_t     c_s4;
	logic [31:0] ma_s [NIT];
	gcarry_t     ca_s [NIT];
	logic [31:0] qb_s [NIT];
	logic [31:0] mb_s [NIT];
	gcarry_t     cb_s [NIT];
	logic [32:0] pc_s [NIT];
	gcarry_t     cc_s [NIT];
	logic [32:0] e_s26;
	logic [31:0] v_s27;
	logic [31:0] pad_s [PAD];

	logic [40:0] t_full;
	logic [18:0] tt;
	logic [22:0] yy;
	logic [47:0] gprod;
	logic [64:0] vprod;

	assign t_full = prod_s1[64:24];
	assign tt     = t_full[18:0];
	assign yy     = y_s3[52:30];
	assign gprod  = {16'd0, yy[15:0]} * {16'd0, K_LN2};
	assign vprod  = {33'd0, sm} * {32'd0, e_s26};

	// Front: distance times rate, square, times log2(e), fraction times ln2
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1   <= {32'd0, dm} * {33'd0, rate};
			tsq_s2    <= {19'd0, tt} * {19'd0, tt};
			zero_s2   <= (t_full >= 41'd327680);
			y_s3      <= {31'd0, tsq_s2[37:16]} * {21'd0, K_LOG2E};
			zero_s3   <= zero_s2;
			c_s4.g    <= gprod[47:16];
			c_s4.n    <= yy[22:16];
			c_s4.zero <= zero_s3;
		end
	end

	// Series p = 1 - g*p/k for k = 7 down to 1, three stages per term
	for (genvar j = 0; j < NIT; j++) begin : g_term
		localparam logic [2:0] KD = 3'(NIT - j);
		localparam logic [35:0] RC = recip_of(KD);
		logic [32:0] p_in;
		gcarry_t     c_in;
		logic [64:0] gp;
		logic [67:0] qp;
		logic [34:0] r;
		logic [31:0] q;

		if (j == 0) begin : g_first
			assign p_in = 33'h1_0000_0000;
			assign c_in = c_s4;
		end else begin : g_next
			assign p_in = pc_s[j-1];
			assign c_in = cc_s[j-1];
		end

		assign gp = {33'd0, c_in.g} * {32'd0, p_in};
		assign qp = {36'd0, ma_s[j]} * {32'd0, RC};
		assign r  = {3'd0, mb_s[j]} - ({3'd0, qb_s[j]} * {32'd0, KD});
		assign q  = (r >= {32'd0, KD}) ? (qb_s[j] + 32'd1) : qb_s[j];

		always_ff @(posedge clk) begin
			if (en) begin
				ma_s[j] <= gp[63:32];
				ca_s[j] <= c_in;
				qb_s[j] <= qp[66:35];
				mb_s[j] <= ma_s[j];
				cb_s[j] <= ca_s[j];
				pc_s[j] <= 33'h1_0000_0000 - {1'b0, q};
				cc_s[j] <= cb_s[j];
			end
		end
	end

	// Back: power-of-two shift, then scale; pad to the common depth
	always_ff @(posedge clk) begin
		if (en) begin
			if (cc_s[NIT-1].zero || (cc_s[NIT-1].n > 7'd32)) begin
				e_s26 <= 33'd0;
			end else begin
				e_s26 <= pc_s[NIT-1] >> cc_s[NIT-1].n;
			end
			v_s27    <= vprod[63:32];
			pad_s[0] <= v_s27;
			for (int i = 1; i < PAD; i++) begin
				pad_s[i] <= pad_s[i-1];
			end
		end
	end

	assign mag = pad_s[PAD-1];

endmodule

/* sv/ppe_lorentz.sv */
// Lorentzian pipeline: scaled distance, 1+u^2, and a one-bit-per-stage divider
module ppe_lorentz (
	input  logic        clk,
	input  logic        en,
	input  logic [32:0] dm,
	input  logic [31:0] ihw,
	input  logic [31:0] sm,
	output logic [31:0] mag
);
	import ppe_pkg::*;

	localparam int QB = PIPE_LAT - 3;

	logic [64:0] prod_s1;
	logic [63:0] usq_s2;
	logic [48:0] den_s3;
	logic [48:0] rem_s [QB+1];
	logic [31:0] low_s [QB+1];
	logic [48:0] den_s [QB+1];

	logic [40:0] u;
	logic [31:0] uc;
	logic [64:0] den_full;

	assign u        = prod_s1[64:24];
	assign uc       = (u > 41'hFFFF0000) ? 32'hFFFF0000 : u[31:0];
	assign den_full = {1'b0, usq_s2} + 65'h1_0000_0000;

	// Front: distance times inverse half width, square, denominator
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= {32'd0, dm} * {33'd0, ihw};
			usq_s2  <= {32'd0, uc} * {32'd0, uc};
			den_s3  <= den_full[64:16];
		end
	end

	// Dividend is scale << 16; its top 16 bits always sit below the divisor
	assign rem_s[0] = {33'd0, sm[31:16]};
	assign low_s[0] = {sm[15:0], 16'd0};
	assign den_s[0] = den_s3;

	for (genvar i = 0; i < QB; i++) begin : g_div
		logic [49:0] rem_sh;
		logic        ge;
		logic [49:0] rem_nx;

		assign rem_sh = {rem_s[i], low_s[i][31]};
		assign ge     = (rem_sh >= {1'b0, den_s[i]});
		assign rem_nx = ge ? (rem_sh - {1'b0, den_s[i]}) : rem_sh;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= rem_nx[48:0];
				low_s[i+1] <= {low_s[i][30:0], ge};
				den_s[i+1] <= den_s[i];
			end
		end
	end

	assign mag = low_s[QB];

endmodule

/* sv/peak_profile_evaluator.sv */
// Top level of the peak profile evaluator: registers, difference stage, shape pipes, output queue
// Evaluates a Gaussian or Lorentzian line shape at one sample position per item, in signed
// Q16.16. One item enters per clock cycle while the input is open; each result passes the
// difference stage, 35 shared pipeline stages set by the 32-stage Lorentzian divider, and a
// two-entry output queue that keeps the input open while a result waits. Coefficients come
// from one shared radix-2 divider that runs four 64-step divisions: after reset and after each
// register write the input holds off until they end. Registers sit at byte addresses 0, 4, 8,
// 12: shape_mode, peak_center, full_width_half_max, peak_intensity. A zero width gives value 0
// with bad_width set; a clipped coefficient sets saturated on every result of its shape.
module peak_profile_evaluator (
	input  logic          clk,
	input  logic          arst_n,
	ppe_stream_if.sink    in_ch,
	ppe_stream_if.source  out_ch,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);
	import ppe_pkg::*;

	localparam int LAST = PIPE_LAT + 1;

	logic        mode_q;
	logic [31:0] center_q, fwhm_q, inten_q;
	coef_t       coef;
	logic        cfg_wr;

	logic        vld_s [1:LAST];
	logic        last_s [1:LAST];
	logic [32:0] dm_s1;

	out_item_t   fifo_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  cnt_q;

	logic        en, in_acc, push, pop;
	logic [32:0] diff;
	logic [31:0] gsm, lsm, gmag, lmag, vmag;
	logic        vneg;
	out_item_t   res;

	// Register port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			center_q <= 32'd0;
			fwhm_q   <= 32'd65536;
			inten_q  <= 32'd65536;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_MODE:   mode_q   <= pwdata[0];
				REG_CENTER: center_q <= pwdata;
				REG_FWHM:   fwhm_q   <= pwdata;
				default:    inten_q  <= pwdata;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_MODE:   prdata = {31'd0, mode_q};
			REG_CENTER: prdata = center_q;
			REG_FWHM:   prdata = fwhm_q;
			default:    prdata = inten_q;
		endcase
	end

	ppe_coef u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cfg_wr),
		.fwhm      (fwhm_q),
		.intensity (inten_q),
		.coef      (coef)
	);

	// Advance the pipe whenever the output queue has room
	assign en           = (cnt_q != 2'd2);
	assign in_ch.ready  = en && !coef.busy;
	assign in_acc       = in_ch.valid && in_ch.ready;
	assign diff         = {in_ch.data.sample_position[31], in_ch.data.sample_position}
		- {center_q[31], center_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAST; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[1] <= in_acc;
			for (int i = 2; i <= LAST; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dm_s1     <= diff[32] ? (33'd0 - diff) : diff;
			last_s[1] <= in_ch.data.last_sample;
			for (int i = 2; i <= LAST; i++) begin
				last_s[i] <= last_s[i-1];
			end
		end
	end

	assign gsm = mag32(coef.gauss_scale);
	assign lsm = mag32(coef.lorentz_scale);

	ppe_gauss u_gauss (
		.clk  (clk),
		.en   (en),
		.dm   (dm_s1),
		.rate (coef.gauss_rate),
		.sm   (gsm),
		.mag  (gmag)
	);

	ppe_lorentz u_lorentz (
		.clk  (clk),
		.en   (en),
		.dm   (dm_s1),
		.ihw  (coef.inverse_half_width),
		.sm   (lsm),
		.mag  (lmag)
	);

	// Apply sign, flags and the zero-width override
	always_comb begin
		vmag           = mode_q ? lmag : gmag;
		vneg           = mode_q ? coef.lorentz_scale[31] : coef.gauss_scale[31];
		res.last_out   = last_s[LAST];
		if (fwhm_q == 32'd0) begin
			res.peak_value = 32'sd0;
			res.saturated  = 1'b0;
			res.bad_width  = 1'b1;
		end else begin
			res.peak_value = vneg ? (32'd0 - vmag) : vmag;
			res.saturated  = mode_q ? coef.lorentz_clip : coef.gauss_clip;
			res.bad_width  = 1'b0;
		end
	end

	// Output queue
	assign push = en && vld_s[LAST];
	assign pop  = out_ch.valid && out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= res;
		end
	end

	assign out_ch.valid = (cnt_q != 2'd0);
	assign out_ch.data  = fifo_q[rd_ptr_q];

endmodule

/* sv/ppe_checker.sv */
// Port-level checker of the peak profile evaluator and its bind
`include "peak_profile_evaluator_defines.svh"

module ppe_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input ppe_pkg::out_item_t  out_data,
	input logic                cfg_wr
);
	import ppe_pkg::*;

	// A stalled result holds
	`PPE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
	// A zero-width result carries value zero and no saturation
	`PPE_ASSERT_NOW(a_bad_width_zero, out_valid && out_data.bad_width, (out_data.peak_value == 32'sd0) && !out_data.saturated)
	// A register write closes the input while coefficients are rebuilt
	`PPE_ASSERT_NEXT(a_cfg_holds_input, cfg_wr, !in_ready)

endmodule

bind peak_profile_evaluator ppe_checker u_ppe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.data),
	.cfg_wr    (psel && penable && pwrite)
);

/* tb/tb_top.sv */
// Self-checking testbench of the peak profile evaluator: stream driver, monitor and line shape predictor
module tb_top;
	import ppe_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] ONE_Q32   = 64'h1_0000_0000;
	localparam logic [63:0] LIM32     = 64'hFFFF_FFFF;
	localparam int          DRAIN_CYC = PIPE_LAT + 20;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite, pready;
	logic [3:0]  paddr;
	logic [31:0] pwdata, prdata;

	ppe_stream_if #(.item_t(in_item_t))  in_ch ();
	ppe_stream_if #(.item_t(out_item_t)) out_ch ();

	peak_profile_evaluator dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Shadow registers and derived coefficients
	logic        sh_mode;
	logic [31:0] sh_center, sh_fwhm, sh_inten;
	logic [31:0] c_gscale, c_grate, c_lscale, c_ihw;
	logic        c_gclip, c_lclip;

	in_item_t  pending_samples[$];
	out_item_t expected_values[$];

	int  snd_gap, rcv_gap, stall_left;
	bit  idle_en, stall_req, in_took;
	int  errors, mismatches, n_items, n_results, n_writes;

	always #4 clk = ~clk;

	function automatic logic [63:0] mag64(input logic [63:0] v);
		return v[63] ? (64'd0 - v) : v;
	endfunction

	function automatic logic [31:0] scale_coef(input logic [63:0] k, input logic [63:0] w,
			inout logic clip);
		logic [63:0] im, q, lim;
		logic        neg;
		neg = sh_inten[31];
		im = mag64({{32{sh_inten[31]}}, sh_inten});
		q = ((im * k) / w) >> 14;
		lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
		if (q > lim) begin
			q = lim;
			clip = 1'b1;
		end
		q = neg ? (64'd0 - q) : q;
		return q[31:0];
	endfunction

	function automatic logic [31:0] rate_coef(input logic [63:0] top, input logic [63:0] w,
			inout logic clip);
		logic [63:0] q;
		q = top / w;
		if (q > LIM32) begin
			q = LIM32;
			clip = 1'b1;
		end
		return q[31:0];
	endfunction

	// Recompute coefficients from the shadow registers
	task automatic derive_coefs();
		logic [63:0] w;
		logic        gc, lc;
		w = mag64({{32{sh_fwhm[31]}}, sh_fwhm});
		gc = 1'b0;
		lc = 1'b0;
		c_gscale = '0; c_grate = '0; c_lscale = '0; c_ihw = '0;
		if (w != 0) begin
			c_gscale = scale_coef(64'(K_GSCALE), w, gc);
			c_grate  = rate_coef(64'(K_GRATE) << 10, w, gc);
			c_lscale = scale_coef(64'(K_LSCALE), w, lc);
			c_ihw    = rate_coef(64'd1 << 41, w, lc);
		end
		c_gclip = gc;
		c_lclip = lc;
	endtask

	// exp(-z) for z in Q16.16, result Q0.32
	function automatic logic [63:0] exp_neg_q32(input logic [63:0] z);
		logic [63:0] y, n, g, p;
		y = (z * 64'(K_LOG2E)) >> 30;
		n = y >> 16;
		g = ((y & 64'hFFFF) * 64'(K_LN2)) >> 16;
		p = ONE_Q32;
		for (int k = 7; k >= 1; k--)
			p = ONE_Q32 - ((g * p) >> 32) / 64'(k);
		if (n > 32)
			return 64'd0;
		return p >> n;
	endfunction

	// Line shape value of one sample under the current coefficients
	function automatic out_item_t line_shape(input in_item_t s);
		out_item_t   r;
		logic [63:0] dm, t, e, u, den, sm, v;
		logic [31:0] scale;
		r.last_out = s.last_sample;
		if (sh_fwhm == 32'd0) begin
			r.peak_value = '0;
			r.saturated = 1'b0;
			r.bad_width = 1'b1;
			return r;
		end
		dm = mag64(64'(signed'(s.sample_position)) - 64'(signed'(sh_center)));
		if (!sh_mode) begin
			t = (dm * 64'(c_grate)) >> 24;
			e = 0;
			if (t < (64'd5 << 16))
				e = exp_neg_q32((t * t) >> 16);
			scale = c_gscale;
			sm = 64'(mag32(scale));
			v = (sm * e) >> 32;
			r.saturated = c_gclip;
		end else begin
			u = (dm * 64'(c_ihw)) >> 24;
			if (u > 64'hFFFF_0000)
				u = 64'hFFFF_0000;
			den = (ONE_Q32 + u * u) >> 16;
			scale = c_lscale;
			sm = 64'(mag32(scale));
			v = (sm << 16) / den;
			r.saturated = c_lclip;
		end
		v = scale[31] ? (64'd0 - v) : v;
		r.peak_value = v[31:0];
		r.bad_width = 1'b0;
		return r;
	endfunction

	// Register write: setup cycle, then access cycle
	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_MODE:   sh_mode = val[0];
			REG_CENTER: sh_center = val;
			REG_FWHM:   sh_fwhm = val;
			default:    sh_inten = val;
		endcase
		derive_coefs();
		n_writes++;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	// Wait until the block has drained every queued item
	task automatic wait_drained();
		wait (pending_samples.size() == 0 && !in_ch.valid && expected_values.size() == 0);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic set_config(input logic mode, input logic [31:0] ctr,
			input logic [31:0] fw, input logic [31:0] inten);
		wait_drained();
		reg_write(REG_MODE, {31'd0, mode});
		reg_write(REG_CENTER, ctr);
		reg_write(REG_FWHM, fw);
		reg_write(REG_INTEN, inten);
	endtask

	task automatic push_sample(input logic [31:0] x, input logic last);
		in_item_t s;
		s.sample_position = x;
		s.last_sample = last;
		pending_samples.push_back(s);
	endtask

	function automatic logic [31:0] rand_mag_word();
		int          e;
		logic [31:0] m;
		e = $urandom_range(1, 31);
		m = ($urandom & ((32'd1 << e) - 1)) | (32'd1 << (e - 1));
		return $urandom_range(0, 1) ? (32'd0 - m) : m;
	endfunction

	// Mostly samples near the center, within a few widths; some anywhere
	task automatic push_random_samples(input int n);
		logic [63:0] w, off;
		w = mag64({{32{sh_fwhm[31]}}, sh_fwhm});
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) < 8) begin
				off = (64'($urandom) << 32 | 64'($urandom)) % (4 * w + 2) - 2 * w;
				push_sample(sh_center + off[31:0], $urandom_range(0, 7) == 0);
			end else begin
				push_sample($urandom, $urandom_range(0, 1));
			end
		end
	endtask

	// Input driver: next item after a handshake, with random gaps
	always @(negedge clk) begin
		logic     v_n;
		in_item_t d_n;
		v_n = in_ch.valid;
		d_n = in_ch.data;
		if (!arst_n) begin
			v_n = 1'b0;
		end else if (!in_ch.valid || in_took) begin
			v_n = 1'b0;
			if (snd_gap > 0) begin
				snd_gap--;
			end else if (pending_samples.size() > 0) begin
				d_n = pending_samples.pop_front();
				v_n = 1'b1;
				if (idle_en && $urandom_range(0, 5) == 0)
					snd_gap = $urandom_range(1, 8);
			end
		end
		in_ch.valid <= v_n;
		in_ch.data <= d_n;
	end

	// Output ready: random bursts, and one long hold-off on request
	always @(negedge clk) begin
		logic r_n;
		r_n = 1'b1;
		if (stall_req && stall_left == 0) begin
			stall_left = 400;
			stall_req = 1'b0;
		end
		if (stall_left > 0) begin
			stall_left--;
			r_n = 1'b0;
		end else if (rcv_gap > 0) begin
			rcv_gap--;
			r_n = 1'b0;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			rcv_gap = $urandom_range(1, 8);
			r_n = 1'b0;
		end
		out_ch.ready <= arst_n ? r_n : 1'b0;
	end

	// Monitor: predict on accepted samples, compare accepted results
	always @(posedge clk) begin
		out_item_t want, got;
		in_took = arst_n && in_ch.valid && in_ch.ready;
		if (in_took) begin
			expected_values.push_back(line_shape(in_ch.data));
			n_items++;
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			n_results++;
			if (expected_values.size() == 0) begin
				errors++;
				if (mismatches++ < 10)
					$display("unexpected result %h", got);
			end else begin
				want = expected_values.pop_front();
				if (got.peak_value !== want.peak_value || got.saturated !== want.saturated ||
						got.bad_width !== want.bad_width || got.last_out !== want.last_out) begin
					errors++;
					if (mismatches++ < 10)
						$display("mismatch: expected value %h sat %b bad %b last %b, got %h %b %b %b",
							want.peak_value, want.saturated, want.bad_width, want.last_out,
							got.peak_value, got.saturated, got.bad_width, got.last_out);
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("peak_profile_evaluator regression: fail");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_ch.valid = 1'b0; in_ch.data = '0; out_ch.ready = 1'b0;
		snd_gap = 0; rcv_gap = 0; stall_left = 0;
		idle_en = 1'b1; stall_req = 1'b0; in_took = 1'b0;
		errors = 0; mismatches = 0; n_items = 0; n_results = 0; n_writes = 0;
		sh_mode = 1'b0; sh_center = '0; sh_fwhm = 32'd65536; sh_inten = 32'd65536;
		derive_coefs();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Directed: reset configuration, field extremes
		push_sample(32'h8000_0000, 1'b0);
		push_sample(32'h7FFF_FFFF, 1'b1);
		push_sample(32'd0, 1'b0);
		push_sample(32'd32768, 1'b0);
		push_sample(32'hFFFF_0000, 1'b1);
		// Lorentzian, negative width, negative intensity, far center
		set_config(1'b1, 32'h8000_0000, 32'hFFFE_0000, 32'hFFF0_0000);
		push_sample(32'h8000_0000, 1'b0);
		push_sample(32'h7FFF_FFFF, 1'b1);
		push_sample(32'h8001_0000, 1'b0);
		// Zero width in both shapes
		set_config(1'b1, 32'd0, 32'd0, 32'd65536);
		push_sample(32'd0, 1'b1);
		push_sample(32'h1234_5678, 1'b0);
		set_config(1'b0, 32'd0, 32'd0, 32'd65536);
		push_sample(32'd0, 1'b0);
		// Clipped coefficients: tiny width, extreme intensities
		set_config(1'b0, 32'h7FFF_FFFF, 32'd1, 32'h8000_0000);
		push_sample(32'h7FFF_FFFF, 1'b0);
		push_sample(32'h7FFF_FFFE, 1'b1);
		set_config(1'b1, 32'd0, 32'd1, 32'h7FFF_FFFF);
		push_sample(32'd0, 1'b0);
		push_sample(32'd1, 1'b0);
		// Widest width
		set_config(1'b0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF);
		push_sample(32'd0, 1'b0);
		push_sample(32'h4000_0000, 1'b1);
		push_sample(32'h8000_0000, 1'b0);

		// Random phases with random settings
		for (int ph = 0; ph < 12; ph++) begin
			set_config($urandom_range(0, 1), $urandom_range(0, 3) == 0 ? $urandom :
				rand_mag_word() >>> 4, $urandom_range(0, 15) == 0 ? 32'd0 : rand_mag_word(),
				rand_mag_word());
			if (ph == 4)
				stall_req = 1'b1;
			if (ph >= 10)
				idle_en = 1'b0;
			push_random_samples(100);
		end
		wait_drained();

		$display("covered %0d samples, %0d results, %0d register writes",
			n_items, n_results, n_writes);
		$display("both line shapes, zero and negative widths, clipped coefficients, stalls");
		if (errors == 0 && expected_values.size() == 0)
			$display("peak_profile_evaluator regression: pass");
		else
			$display("peak_profile_evaluator regression: fail");
		$finish;
	end
endmodule
